### rtl/ole_pkg.sv
`timescale 1ns / 1ps
// Package for the ordered list engine: list depth, derived widths,
// command and status codes and the sequencer state type. No dependencies.
package ole_pkg;

    // List capacity and the widths that follow from it.
    localparam int DEPTH  = 16;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Fixed field widths of the stream payloads.
    localparam int CMD_W   = 3;
    localparam int DATA_W  = 32;
    localparam int POS_W   = 5;
    localparam int STAT_W  = 2;
    localparam int OCNT_W  = 5;
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    // Command codes.
    typedef enum logic [CMD_W-1:0] {
        CMD_INS_HEAD = 3'd0,
        CMD_INS_TAIL = 3'd1,
        CMD_INS_POS  = 3'd2,
        CMD_DEL_HEAD = 3'd3,
        CMD_DEL_TAIL = 3'd4,
        CMD_DEL_POS  = 3'd5,
        CMD_SEARCH   = 3'd6
    } cmd_t;

    // Status codes.
    typedef enum logic [STAT_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_EMPTY  = 2'd1,
        STAT_FULL   = 2'd2,
        STAT_BADPOS = 2'd3
    } status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WR,
        S_DEL_CAP,
        S_DEL_RD,
        S_DEL_WR,
        S_SRCH_CMP,
        S_RESP
    } state_t;

endpackage

### rtl/ole_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module ole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/ordered_list_engine.sv
`timescale 1ns / 1ps
// Ordered list engine top level: command sequencer over one entry RAM.
// Depends on ole_pkg and ole_ram.
//
//   Channel   Direction  Payload (tdata, low bit first)
//   s_axis    in         cmd[2:0], value[34:3], position[39:35]
//   m_axis    out        status[1:0], removed_value[33:2], found[34], entry_count[39:35]
//
// One command is in work at a time. Commands that fail their checks, and the
// unused code, go straight to the result state. An insert or delete moves each
// entry behind the given place with one RAM read and one write; a search
// compares one entry per cycle.
// Reset clears the count, the sequencer and the result valid; the RAM is not
// cleared. A new command is taken while a result still waits on m_tready.
module ordered_list_engine (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // cmd[2:0], value[34:3], position[39:35]
    input  logic [ole_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // status[1:0], removed_value[33:2], found[34], entry_count[39:35]
    output logic [ole_pkg::OUT_TDATA_W-1:0]   m_tdata
);

    ole_pkg::state_t state_reg, state_next;

    logic [ole_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [ole_pkg::ADDR_W-1:0] ptr_reg, ptr_next;
    logic [ole_pkg::ADDR_W-1:0] idx_reg, idx_next;
    logic [ole_pkg::DATA_W-1:0] val_reg, val_next;
    logic [ole_pkg::DATA_W-1:0] removed_reg, removed_next;
    logic                       found_reg, found_next;
    ole_pkg::status_t           status_reg, status_next;

    logic                          m_tvalid_reg, m_tvalid_next;
    logic [ole_pkg::OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // RAM port signals.
    logic                       ram_we;
    logic [ole_pkg::ADDR_W-1:0] ram_waddr;
    logic [ole_pkg::DATA_W-1:0] ram_wdata;
    logic [ole_pkg::ADDR_W-1:0] ram_raddr;
    logic [ole_pkg::DATA_W-1:0] ram_rdata;

    // Input fields.
    logic [ole_pkg::CMD_W-1:0]  in_cmd;
    logic [ole_pkg::DATA_W-1:0] in_value;
    logic [ole_pkg::POS_W-1:0]  in_pos;

    // Command decode results.
    ole_pkg::state_t            dec_state;
    ole_pkg::status_t           dec_status;
    logic [ole_pkg::ADDR_W-1:0] dec_idx;

    logic s_accept;
    logic out_free;
    logic list_full;
    logic list_empty;
    logic pos_ok;
    logic [ole_pkg::CMP_W-1:0]  pos_ext;
    logic [ole_pkg::CMP_W-1:0]  cnt_ext;
    logic [ole_pkg::CMP_W-1:0]  pos_m1;
    logic [ole_pkg::CNT_W-1:0]  cnt_m1;
    logic [ole_pkg::CNT_W-1:0]  ptr_p1;

    assign in_cmd   = s_tdata[2:0];
    assign in_value = s_tdata[34:3];
    assign in_pos   = s_tdata[39:35];

    assign s_tready = (state_reg == ole_pkg::S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Range checks against the current count.
    assign list_full  = (count_reg == ole_pkg::CNT_W'(ole_pkg::DEPTH));
    assign list_empty = (count_reg == '0);
    assign pos_ext    = ole_pkg::CMP_W'(in_pos);
    assign cnt_ext    = ole_pkg::CMP_W'(count_reg);
    assign pos_ok     = (pos_ext != '0) && (pos_ext <= cnt_ext);
    assign pos_m1     = pos_ext - ole_pkg::CMP_W'(1);
    assign cnt_m1     = count_reg - ole_pkg::CNT_W'(1);
    assign ptr_p1     = ole_pkg::CNT_W'(ptr_reg) + ole_pkg::CNT_W'(1);

    // Command decoder: checks and the place in the list to work on.
    always_comb begin
        dec_state  = ole_pkg::S_RESP;
        dec_status = ole_pkg::STAT_OK;
        dec_idx    = '0;
        unique case (in_cmd)
            ole_pkg::CMD_INS_HEAD: begin
                if (list_full) begin
                    dec_status = ole_pkg::STAT_FULL;
                end else begin
                    dec_state = ole_pkg::S_INS_RD;
                end
            end
            ole_pkg::CMD_INS_TAIL: begin
                if (list_full) begin
                    dec_status = ole_pkg::STAT_FULL;
                end else begin
                    dec_state = ole_pkg::S_INS_RD;
                    dec_idx   = count_reg[ole_pkg::ADDR_W-1:0];
                end
            end
            ole_pkg::CMD_INS_POS: begin
                if (list_empty) begin
                    dec_status = ole_pkg::STAT_EMPTY;
                end else if (!pos_ok) begin
                    dec_status = ole_pkg::STAT_BADPOS;
                end else if (list_full) begin
                    dec_status = ole_pkg::STAT_FULL;
                end else begin
                    dec_state = ole_pkg::S_INS_RD;
                    dec_idx   = pos_m1[ole_pkg::ADDR_W-1:0];
                end
            end
            ole_pkg::CMD_DEL_HEAD: begin
                if (list_empty) begin
                    dec_status = ole_pkg::STAT_EMPTY;
                end else begin
                    dec_state = ole_pkg::S_DEL_CAP;
                end
            end
            ole_pkg::CMD_DEL_TAIL: begin
                if (list_empty) begin
                    dec_status = ole_pkg::STAT_EMPTY;
                end else begin
                    dec_state = ole_pkg::S_DEL_CAP;
                    dec_idx   = cnt_m1[ole_pkg::ADDR_W-1:0];
                end
            end
            ole_pkg::CMD_DEL_POS: begin
                if (list_empty) begin
                    dec_status = ole_pkg::STAT_EMPTY;
                end else if (!pos_ok) begin
                    dec_status = ole_pkg::STAT_BADPOS;
                end else begin
                    dec_state = ole_pkg::S_DEL_CAP;
                    dec_idx   = pos_m1[ole_pkg::ADDR_W-1:0];
                end
            end
            ole_pkg::CMD_SEARCH: begin
                if (list_empty) begin
                    dec_status = ole_pkg::STAT_EMPTY;
                end else begin
                    dec_state = ole_pkg::S_SRCH_CMP;
                end
            end
            default: begin
                dec_state  = ole_pkg::S_RESP;
                dec_status = ole_pkg::STAT_OK;
            end
        endcase
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ole_pkg::S_IDLE: begin
                if (s_accept) begin
                    state_next = dec_state;
                end
            end
            ole_pkg::S_INS_RD: begin
                if (ptr_reg > idx_reg) begin
                    state_next = ole_pkg::S_INS_WR;
                end else begin
                    state_next = ole_pkg::S_RESP;
                end
            end
            ole_pkg::S_INS_WR: begin
                state_next = ole_pkg::S_INS_RD;
            end
            ole_pkg::S_DEL_CAP: begin
                state_next = ole_pkg::S_DEL_RD;
            end
            ole_pkg::S_DEL_RD: begin
                if (ptr_p1 < count_reg) begin
                    state_next = ole_pkg::S_DEL_WR;
                end else begin
                    state_next = ole_pkg::S_RESP;
                end
            end
            ole_pkg::S_DEL_WR: begin
                state_next = ole_pkg::S_DEL_RD;
            end
            ole_pkg::S_SRCH_CMP: begin
                if ((ram_rdata == val_reg) || (ptr_p1 == count_reg)) begin
                    state_next = ole_pkg::S_RESP;
                end
            end
            ole_pkg::S_RESP: begin
                if (out_free) begin
                    state_next = ole_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = ole_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath, RAM accesses and result register.
    always_comb begin
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        idx_next      = idx_reg;
        val_next      = val_reg;
        removed_next  = removed_reg;
        found_next    = found_reg;
        status_next   = status_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        ram_we        = 1'b0;
        ram_waddr     = ptr_reg;
        ram_wdata     = ram_rdata;
        ram_raddr     = ptr_reg;
        unique case (state_reg)
            ole_pkg::S_IDLE: begin
                // Start the first read of a delete or a search right away.
                ram_raddr = dec_idx;
                if (s_accept) begin
                    val_next     = in_value;
                    status_next  = dec_status;
                    removed_next = '0;
                    found_next   = 1'b0;
                    idx_next     = dec_idx;
                    if (dec_state == ole_pkg::S_INS_RD) begin
                        ptr_next = count_reg[ole_pkg::ADDR_W-1:0];
                    end else begin
                        ptr_next = dec_idx;
                    end
                end
            end
            ole_pkg::S_INS_RD: begin
                // Read the entry in front of the pointer, or place the new word.
                ram_raddr = ptr_reg - ole_pkg::ADDR_W'(1);
                if (ptr_reg <= idx_reg) begin
                    ram_we     = 1'b1;
                    ram_waddr  = idx_reg;
                    ram_wdata  = val_reg;
                    count_next = count_reg + ole_pkg::CNT_W'(1);
                end
            end
            ole_pkg::S_INS_WR: begin
                // Move the entry one place toward the tail.
                ram_we    = 1'b1;
                ram_waddr = ptr_reg;
                ptr_next  = ptr_reg - ole_pkg::ADDR_W'(1);
            end
            ole_pkg::S_DEL_CAP: begin
                removed_next = ram_rdata;
            end
            ole_pkg::S_DEL_RD: begin
                // Read the entry behind the pointer, or finish the delete.
                ram_raddr = ptr_p1[ole_pkg::ADDR_W-1:0];
                if (ptr_p1 >= count_reg) begin
                    count_next = cnt_m1;
                end
            end
            ole_pkg::S_DEL_WR: begin
                // Move the entry one place toward the head.
                ram_we    = 1'b1;
                ram_waddr = ptr_reg;
                ptr_next  = ptr_p1[ole_pkg::ADDR_W-1:0];
            end
            ole_pkg::S_SRCH_CMP: begin
                // Compare one entry per cycle while the next one is read.
                ram_raddr = ptr_p1[ole_pkg::ADDR_W-1:0];
                if (ram_rdata == val_reg) begin
                    found_next = 1'b1;
                end else if (ptr_p1 != count_reg) begin
                    ptr_next = ptr_p1[ole_pkg::ADDR_W-1:0];
                end
            end
            ole_pkg::S_RESP: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {ole_pkg::OCNT_W'(count_reg), found_reg,
                                     removed_reg, status_reg};
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ole_pkg::S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        ptr_reg     <= ptr_next;
        idx_reg     <= idx_next;
        val_reg     <= val_next;
        removed_reg <= removed_next;
        found_reg   <= found_next;
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
    end

    // Entry store.
    ole_ram #(
        .WIDTH (ole_pkg::DATA_W),
        .DEPTH (ole_pkg::DEPTH)
    ) u_entries (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for ordered_list_engine: a directed table, then random
// command mixes under several idling patterns, checked by a queue-based list model.
// Depends on ole_pkg and the RTL of the engine.
module testbench;

    // Code that no command uses; the engine must treat it as a no-op.
    localparam logic [ole_pkg::CMD_W-1:0] CMD_UNUSED = 3'd7;
    // Cycles without any transaction before the run is declared hung.
    localparam int QUIET_LIMIT = 5000;
    // Length of the long receiver hold-off.
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_PER_PHASE = 400;

    // Input transaction: cmd in the low bits, then value, then position.
    typedef struct packed {
        logic [ole_pkg::POS_W-1:0]  position;
        logic [ole_pkg::DATA_W-1:0] value;
        logic [ole_pkg::CMD_W-1:0]  cmd;
    } list_cmd_t;

    // Result transaction: status in the low bits, then removed value, found, count.
    typedef struct packed {
        logic [ole_pkg::OCNT_W-1:0] entry_count;
        logic                       found;
        logic [ole_pkg::DATA_W-1:0] removed_value;
        ole_pkg::status_t           status;
    } list_result_t;

    typedef struct {
        list_cmd_t    command;
        bit           typed;
        list_result_t result;
    } directed_row_t;

    typedef enum {MIX_FILL, MIX_BALANCED, MIX_DRAIN} op_mix_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [ole_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [ole_pkg::OUT_TDATA_W-1:0] m_tdata;

    logic [ole_pkg::DATA_W-1:0] list_words[$];
    list_result_t               pending_results[$];
    directed_row_t              directed_rows[$];
    int                         mismatch_count = 0;
    int                         sender_idle_pct = 0;
    int                         receiver_stall_pct = 0;
    int                         pressure_due = 0;
    int                         pressure_taken = 0;
    int                         hold_left = 0;
    int                         quiet_cycles = 0;

    ordered_list_engine dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // List model: applies one command to the queue and returns the result it gives.
    function automatic list_result_t apply_list_command(input list_cmd_t c);
        list_result_t r;
        int unsigned  used;
        bit           pos_ok;
        r = '0;
        used = list_words.size();
        pos_ok = (c.position >= 1) && (c.position <= used);
        case (c.cmd)
            ole_pkg::CMD_INS_HEAD: begin
                if (used >= ole_pkg::DEPTH) r.status = ole_pkg::STAT_FULL;
                else list_words.push_front(c.value);
            end
            ole_pkg::CMD_INS_TAIL: begin
                if (used >= ole_pkg::DEPTH) r.status = ole_pkg::STAT_FULL;
                else list_words.push_back(c.value);
            end
            ole_pkg::CMD_INS_POS: begin
                // Empty comes first, then the position, then the full check.
                if (used == 0) r.status = ole_pkg::STAT_EMPTY;
                else if (!pos_ok) r.status = ole_pkg::STAT_BADPOS;
                else if (used >= ole_pkg::DEPTH) r.status = ole_pkg::STAT_FULL;
                else list_words.insert(c.position - 1, c.value);
            end
            ole_pkg::CMD_DEL_HEAD: begin
                if (used == 0) r.status = ole_pkg::STAT_EMPTY;
                else r.removed_value = list_words.pop_front();
            end
            ole_pkg::CMD_DEL_TAIL: begin
                if (used == 0) r.status = ole_pkg::STAT_EMPTY;
                else r.removed_value = list_words.pop_back();
            end
            ole_pkg::CMD_DEL_POS: begin
                if (used == 0) begin
                    r.status = ole_pkg::STAT_EMPTY;
                end else if (!pos_ok) begin
                    r.status = ole_pkg::STAT_BADPOS;
                end else begin
                    r.removed_value = list_words[c.position - 1];
                    list_words.delete(c.position - 1);
                end
            end
            ole_pkg::CMD_SEARCH: begin
                if (used == 0) begin
                    r.status = ole_pkg::STAT_EMPTY;
                end else begin
                    foreach (list_words[i]) begin
                        if (list_words[i] == c.value) r.found = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.entry_count = ole_pkg::OCNT_W'(list_words.size());
        return r;
    endfunction

    // Random command, weighted toward growing, shrinking or churning the list.
    function automatic list_cmd_t random_command(input op_mix_t mix);
        list_cmd_t c;
        int        roll;
        roll = $urandom_range(99);
        case (mix)
            MIX_FILL: c.cmd = roll < 30 ? ole_pkg::CMD_INS_HEAD :
                              roll < 55 ? ole_pkg::CMD_INS_TAIL :
                              roll < 75 ? ole_pkg::CMD_INS_POS :
                              roll < 82 ? ole_pkg::CMD_DEL_HEAD :
                              roll < 88 ? ole_pkg::CMD_DEL_TAIL :
                              roll < 93 ? ole_pkg::CMD_DEL_POS :
                              roll < 98 ? ole_pkg::CMD_SEARCH : CMD_UNUSED;
            MIX_DRAIN: c.cmd = roll < 8 ? ole_pkg::CMD_INS_HEAD :
                               roll < 14 ? ole_pkg::CMD_INS_TAIL :
                               roll < 20 ? ole_pkg::CMD_INS_POS :
                               roll < 40 ? ole_pkg::CMD_DEL_HEAD :
                               roll < 60 ? ole_pkg::CMD_DEL_TAIL :
                               roll < 85 ? ole_pkg::CMD_DEL_POS :
                               roll < 97 ? ole_pkg::CMD_SEARCH : CMD_UNUSED;
            default: c.cmd = roll < 96 ? ole_pkg::CMD_W'($urandom_range(6)) : CMD_UNUSED;
        endcase
        // Values: fully random, a small pool for duplicates, present words, extremes.
        case ($urandom_range(3))
            0: c.value = $urandom();
            1: c.value = $urandom_range(7);
            2: c.value = (list_words.size() != 0) ?
                         list_words[$urandom_range(list_words.size() - 1)] : $urandom();
            default: begin
                case ($urandom_range(3))
                    0: c.value = 32'h8000_0000;
                    1: c.value = 32'h7FFF_FFFF;
                    2: c.value = 32'hFFFF_FFFF;
                    default: c.value = 32'h0000_0000;
                endcase
            end
        endcase
        // Mostly positions inside the list, the rest anywhere in the field.
        if (list_words.size() != 0 && $urandom_range(9) < 8) begin
            c.position = ole_pkg::POS_W'($urandom_range(list_words.size(), 1));
        end else begin
            c.position = ole_pkg::POS_W'($urandom_range(31));
        end
        return c;
    endfunction

    task automatic add_row(input logic [ole_pkg::CMD_W-1:0] cmd,
                           input logic [ole_pkg::DATA_W-1:0] value,
                           input logic [ole_pkg::POS_W-1:0] position, input bit typed,
                           input ole_pkg::status_t status,
                           input logic [ole_pkg::DATA_W-1:0] removed,
                           input logic found, input logic [ole_pkg::OCNT_W-1:0] count);
        directed_row_t row;
        row.command.cmd = cmd;
        row.command.value = value;
        row.command.position = position;
        row.typed = typed;
        row.result.status = status;
        row.result.removed_value = removed;
        row.result.found = found;
        row.result.entry_count = count;
        directed_rows.push_back(row);
    endtask

    // Offer one command after a random idle gap; on acceptance record what it must return.
    task automatic offer_command(input list_cmd_t c, input bit typed,
                                 input list_result_t typed_result);
        list_result_t predicted;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata <= c;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = apply_list_command(c);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    task automatic note_mismatch(input string what, input list_result_t want,
                                 input list_result_t got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t: %s: expected status %0d removed %h found %0d count %0d,",
                     $realtime, what, want.status, want.removed_value, want.found,
                     want.entry_count);
            $display("    got status %0d removed %h found %0d count %0d",
                     got.status, got.removed_value, got.found, got.entry_count);
        end
    endtask

    // Result side: check each transaction, then decide the next ready value.
    always @(posedge aclk) begin
        list_result_t got;
        list_result_t want;
        got = m_tdata;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                note_mismatch("result with nothing pending", '0, got);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status ||
                    got.removed_value !== want.removed_value ||
                    got.found !== want.found || got.entry_count !== want.entry_count) begin
                    note_mismatch("result mismatch", want, got);
                end
            end
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (pressure_taken != pressure_due) begin
            // Long hold-off so the engine backs up and stalls its input.
            m_tready <= 1'b0;
            hold_left <= HOLD_CYCLES - 1;
            pressure_taken <= pressure_taken + 1;
        end else begin
            m_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Watchdog: too long without any transaction on either side ends the run.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        op_mix_t mix;
        // Empty-list cases, the unused code, extremes and bad positions first.
        add_row(ole_pkg::CMD_DEL_HEAD, 32'h0, 5'd0, 1'b1, ole_pkg::STAT_EMPTY,
                32'h0, 1'b0, 5'd0);
        add_row(ole_pkg::CMD_DEL_TAIL, 32'h0, 5'd0, 1'b1, ole_pkg::STAT_EMPTY,
                32'h0, 1'b0, 5'd0);
        add_row(ole_pkg::CMD_DEL_POS, 32'h0, 5'd1, 1'b1, ole_pkg::STAT_EMPTY,
                32'h0, 1'b0, 5'd0);
        add_row(ole_pkg::CMD_SEARCH, 32'h0, 5'd0, 1'b1, ole_pkg::STAT_EMPTY,
                32'h0, 1'b0, 5'd0);
        add_row(ole_pkg::CMD_INS_POS, 32'h5, 5'd1, 1'b1, ole_pkg::STAT_EMPTY,
                32'h0, 1'b0, 5'd0);
        add_row(CMD_UNUSED, 32'hFFFF_FFFF, 5'd31, 1'b1, ole_pkg::STAT_OK,
                32'h0, 1'b0, 5'd0);
        add_row(ole_pkg::CMD_INS_HEAD, 32'h7FFF_FFFF, 5'd0, 1'b1, ole_pkg::STAT_OK,
                32'h0, 1'b0, 5'd1);
        add_row(ole_pkg::CMD_INS_TAIL, 32'h8000_0000, 5'd0, 1'b1, ole_pkg::STAT_OK,
                32'h0, 1'b0, 5'd2);
        add_row(ole_pkg::CMD_INS_POS, 32'h1, 5'd0, 1'b1, ole_pkg::STAT_BADPOS,
                32'h0, 1'b0, 5'd2);
        add_row(ole_pkg::CMD_INS_POS, 32'h1, 5'd3, 1'b1, ole_pkg::STAT_BADPOS,
                32'h0, 1'b0, 5'd2);
        add_row(ole_pkg::CMD_INS_POS, 32'h0, 5'd31, 1'b1, ole_pkg::STAT_BADPOS,
                32'h0, 1'b0, 5'd2);
        add_row(ole_pkg::CMD_DEL_POS, 32'h0, 5'd0, 1'b1, ole_pkg::STAT_BADPOS,
                32'h0, 1'b0, 5'd2);
        add_row(ole_pkg::CMD_DEL_POS, 32'h0, 5'd16, 1'b1, ole_pkg::STAT_BADPOS,
                32'h0, 1'b0, 5'd2);
        // Positional inserts, searches that hit and miss, delete of the last position.
        add_row(ole_pkg::CMD_INS_POS, 32'h0, 5'd2, 1'b0, ole_pkg::STAT_OK,
                32'h0, 1'b0, 5'd0);
        add_row(ole_pkg::CMD_INS_POS, 32'hFFFF_FFFF, 5'd1, 1'b0, ole_pkg::STAT_OK,
                32'h0, 1'b0, 5'd0);
        add_row(ole_pkg::CMD_SEARCH, 32'h8000_0000, 5'd0, 1'b0, ole_pkg::STAT_OK,
                32'h0, 1'b0, 5'd0);
        add_row(ole_pkg::CMD_SEARCH, 32'h1234_5678, 5'd0, 1'b0, ole_pkg::STAT_OK,
                32'h0, 1'b0, 5'd0);
        add_row(ole_pkg::CMD_DEL_POS, 32'h0, 5'd4, 1'b0, ole_pkg::STAT_OK,
                32'h0, 1'b0, 5'd0);
        add_row(ole_pkg::CMD_DEL_POS, 32'h0, 5'd1, 1'b0, ole_pkg::STAT_OK,
                32'h0, 1'b0, 5'd0);
        add_row(CMD_UNUSED, 32'h0, 5'd0, 1'b0, ole_pkg::STAT_OK, 32'h0, 1'b0, 5'd0);
        add_row(ole_pkg::CMD_DEL_HEAD, 32'h0, 5'd0, 1'b0, ole_pkg::STAT_OK,
                32'h0, 1'b0, 5'd0);
        add_row(ole_pkg::CMD_DEL_TAIL, 32'h0, 5'd0, 1'b0, ole_pkg::STAT_OK,
                32'h0, 1'b0, 5'd0);
        add_row(ole_pkg::CMD_SEARCH, 32'h0, 5'd0, 1'b1, ole_pkg::STAT_EMPTY,
                32'h0, 1'b0, 5'd0);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[k]) begin
            offer_command(directed_rows[k].command, directed_rows[k].typed,
                          directed_rows[k].result);
        end

        // Random phases: no idling, idle sender, stalling receiver, both lightly.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 86; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 86; end
                default: begin sender_idle_pct = 12; receiver_stall_pct = 12; end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                // Segments of 40 commands alternate between filling, churning, draining.
                case ((n / 40) % 3)
                    0: mix = MIX_FILL;
                    1: mix = MIX_BALANCED;
                    default: mix = MIX_DRAIN;
                endcase
                if (phase == 0 && n == 100) pressure_due = pressure_due + 1;
                offer_command(random_command(mix), 1'b0, '0);
            end
        end
        s_tvalid <= 1'b0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;

        // Drain, then allow the longest command time for any stray result.
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (2 * ole_pkg::DEPTH + 8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
